>>> hdl/u8sd_pkg.sv
// ----------------------------------------------------------------------------
// u8sd_pkg: shared types and helpers for the utf-8 stream decoder
// Lead-byte classification, buffer sizing and the controller/datapath
// command and status groups.
// ----------------------------------------------------------------------------
package u8sd_pkg;

	// bytes kept across transactions and the working buffer depth
	localparam int HOLD_DEPTH = 5;
	localparam int BUF_DEPTH  = HOLD_DEPTH + 1;
	localparam int CNT_W      = $clog2(BUF_DEPTH + 1);
	localparam int IDX_W      = $clog2(BUF_DEPTH);

	// sequence lengths, zero marks a byte that cannot lead
	localparam logic [2:0] LEN_INVALID = 3'd0;
	localparam logic [2:0] LEN_1       = 3'd1;
	localparam logic [2:0] LEN_2       = 3'd2;
	localparam logic [2:0] LEN_3       = 3'd3;
	localparam logic [2:0] LEN_4       = 3'd4;
	localparam logic [2:0] LEN_5       = 3'd5;
	localparam logic [2:0] LEN_6       = 3'd6;

	// controller to datapath
	typedef struct packed {
		logic load;  // append the accepted byte to the buffer
		logic step;  // emit one result and drop its bytes
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hold;  // lead sequence incomplete and no flush pending
		logic last;  // current result empties the buffer
	} dp_status_t;

	// sequence length keyed on the lead byte only
	function automatic logic [2:0] lead_length(input logic [7:0] b);
		logic [2:0] len;
		if ((b & 8'h80) == 8'h00)      len = LEN_1;
		else if ((b & 8'hE0) == 8'hC0) len = LEN_2;
		else if ((b & 8'hF0) == 8'hE0) len = LEN_3;
		else if ((b & 8'hF8) == 8'hF0) len = LEN_4;
		else if ((b & 8'hFC) == 8'hF8) len = LEN_5;
		else if ((b & 8'hFC) == 8'hFC) len = LEN_6;
		else                           len = LEN_INVALID;
		return len;
	endfunction

endpackage

>>> hdl/u8sd_datapath.sv
// ----------------------------------------------------------------------------
// u8sd_datapath: byte buffer, character assembly and result register
// Holds the bytes of an open sequence, decodes the byte at the head of the
// buffer and shifts consumed bytes out one character per step.
// ----------------------------------------------------------------------------
module u8sd_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  u8sd_pkg::dp_cmd_t    cmd,
	output u8sd_pkg::dp_status_t status,
	input  logic [7:0]           data_byte,
	input  logic                 buffer_end,
	output logic [31:0]          code_point,
	output logic [2:0]           bytes_used,
	output logic                 latin1_fallback,
	output logic                 run_last
);
	import u8sd_pkg::*;

	logic [7:0]       buf_q [BUF_DEPTH];
	logic [CNT_W-1:0] count_q;
	logic             flush_q;

	logic [2:0]       len;
	logic             truncated;
	logic             raw;
	logic [CNT_W-1:0] consume;
	logic [31:0]      cp;
	logic [7:0]       buf_shift [BUF_DEPTH];

	// head-of-buffer classification
	always_comb begin
		len       = lead_length(buf_q[0]);
		truncated = (len != LEN_INVALID) && (CNT_W'(len) > count_q);
		raw       = (len == LEN_INVALID) || truncated;
		consume   = raw ? CNT_W'(1) : CNT_W'(len);
		status.hold = truncated && !flush_q;
		status.last = (count_q == consume);
	end

	// character assembly from fixed buffer positions
	always_comb begin
		case (len)
			LEN_1: cp = {24'd0, buf_q[0]};
			LEN_2: cp = {21'd0, buf_q[0][4:0], buf_q[1][5:0]};
			LEN_3: cp = {16'd0, buf_q[0][3:0], buf_q[1][5:0], buf_q[2][5:0]};
			LEN_4: cp = {11'd0, buf_q[0][2:0], buf_q[1][5:0], buf_q[2][5:0],
				buf_q[3][5:0]};
			LEN_5: cp = {6'd0, buf_q[0][1:0], buf_q[1][5:0], buf_q[2][5:0],
				buf_q[3][5:0], buf_q[4][5:0]};
			LEN_6: cp = {buf_q[0][1:0], buf_q[1][5:0], buf_q[2][5:0],
				buf_q[3][5:0], buf_q[4][5:0], buf_q[5][5:0]};
			default: cp = {24'd0, buf_q[0]};
		endcase
		if (raw) cp = {24'd0, buf_q[0]};
	end

	// drop the consumed bytes from the head
	always_comb begin
		for (int i = 0; i < BUF_DEPTH; i++) begin
			buf_shift[i] = buf_q[i];
			for (int j = 1; j <= BUF_DEPTH; j++) begin
				if ((consume == CNT_W'(j)) && (i + j < BUF_DEPTH))
					buf_shift[i] = buf_q[i + j];
			end
		end
	end

	// buffer contents, undefined until written
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			buf_q[count_q[IDX_W-1:0]] <= data_byte;
		end else if (cmd.step) begin
			for (int i = 0; i < BUF_DEPTH; i++) buf_q[i] <= buf_shift[i];
		end
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.load) begin
			count_q <= count_q + CNT_W'(1);
		end else if (cmd.step) begin
			count_q <= count_q - consume;
		end
	end

	// flush flag of the byte being decoded
	always_ff @(posedge clk) begin
		if (cmd.load) flush_q <= buffer_end;
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			code_point      <= cp;
			bytes_used      <= raw ? LEN_1 : len;
			latin1_fallback <= raw;
			run_last        <= status.last;
		end
	end

	// buffer never overfills
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(BUF_DEPTH))
		else $error("buffer count out of range");

	// a final step leaves nothing held
	a_last_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step && status.last |=> count_q == '0)
		else $error("buffer not empty after final result");

endmodule

>>> hdl/u8sd_ctrl.sv
// ----------------------------------------------------------------------------
// u8sd_ctrl: sequencing state machine for the utf-8 stream decoder
// Accepts one byte, then steps the datapath once per result until the
// buffer is empty or an open sequence is held.
// ----------------------------------------------------------------------------
module u8sd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	output u8sd_pkg::dp_cmd_t    cmd,
	input  u8sd_pkg::dp_status_t status
);
	import u8sd_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'b01,
		ST_DECODE = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// next state and datapath commands
	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.step = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (status.hold) begin
					state_d = ST_IDLE;
				end else if (slot_free) begin
					cmd.step = 1'b1;
					if (status.last) state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.step)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// a result is never written over one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> slot_free)
		else $error("result register overwritten");

	// the final result of a transaction returns the machine to idle
	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step && status.last |=> state_q == ST_IDLE)
		else $error("no return to idle after final result");

endmodule

>>> hdl/utf8_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit: old-style utf-8 decoder with latin-1 fallback
// Byte-in, character-out decoder for one to six byte sequences.
// ----------------------------------------------------------------------------
// Each accepted byte is first loaded into the byte buffer; the state machine
// then steps the buffer one character per result the byte causes, holding
// off while the last result still waits to be collected. A flush at buffer
// end releases every held character in turn. A byte that leaves a sequence
// open produces no result and is held until the sequence completes or the
// buffer ends. Results sit in an output register, so a new byte is taken
// while the last result still waits to be collected.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        buffer_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] code_point,
	output logic [2:0]  bytes_used,
	output logic        latin1_fallback,
	output logic        run_last
);
	import u8sd_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	// sequencing
	u8sd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	// buffer and decode
	u8sd_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.data_byte       (data_byte),
		.buffer_end      (buffer_end),
		.code_point      (code_point),
		.bytes_used      (bytes_used),
		.latin1_fallback (latin1_fallback),
		.run_last        (run_last)
	);

endmodule
